[rtl/core/plfc_pkg.sv]
// Shared types and constants for the prefix-filtered line capture block.
package plfc_pkg;

	localparam int TAG_CHARS = 4;
	localparam logic [1:0] PREFIX_LAST = 2'd3;
	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_U = 8'h55;

	// Pop sequencer states, one-hot
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_POP  = 2'b10
	} pop_state_t;

	// Capture side request to the line store
	typedef struct packed {
		logic wr_en;  // write one byte into the open slot
		logic store;  // commit the open slot as a finished line
	} cap_ctl_t;

	// Line store status toward the input handshake
	typedef struct packed {
		logic pop_busy;    // a line is being read out
		logic drain_busy;  // read stage or output register cannot take an item
	} store_status_t;

	// Characters of the "URC:" prefix
	function automatic logic [7:0] prefix_char(input logic [1:0] idx);
		logic [7:0] c;
		case (idx)
			2'd0: c = 8'h55;
			2'd1: c = 8'h52;
			2'd2: c = 8'h43;
			2'd3: c = 8'h3A;
			default: c = 8'h00;
		endcase
		return c;
	endfunction

endpackage

[rtl/core/plfc_matcher.sv]
// Prefix matcher and line length tracking for received bytes.
module plfc_matcher #(
	parameter int LINE_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          byte_en,
	input  logic [7:0]                    rx_byte,
	output plfc_pkg::cap_ctl_t            ctl,
	output logic [7:0]                    wr_data,
	output logic [$clog2(LINE_BYTES)-1:0] wr_off,
	output logic [$clog2(LINE_BYTES)-1:0] wr_len
);
	import plfc_pkg::*;

	localparam int LW = $clog2(LINE_BYTES);

	logic [1:0]    pm_q, pm_d;
	logic [LW-1:0] len_q, len_d;

	always_comb begin
		ctl    = '0;
		wr_off = '0;
		len_d  = len_q;
		pm_d   = pm_q;
		if (byte_en) begin
			if (rx_byte == CH_CR || rx_byte == CH_LF) begin
				ctl.store = (len_q != '0);
				len_d     = '0;
				pm_d      = '0;
			end else if (len_q != '0) begin
				if (len_q < LW'(LINE_BYTES - 1)) begin
					ctl.wr_en = 1'b1;
					wr_off    = len_q;
					len_d     = len_q + 1'b1;
				end else begin
					// overlong line: drop it
					len_d = '0;
					pm_d  = '0;
				end
			end else if (rx_byte == prefix_char(pm_q)) begin
				ctl.wr_en = 1'b1;
				wr_off    = LW'(pm_q);
				if (pm_q == PREFIX_LAST) begin
					len_d = LW'(TAG_CHARS);
					pm_d  = '0;
				end else begin
					pm_d = pm_q + 1'b1;
				end
			end else if (rx_byte == CH_U) begin
				ctl.wr_en = 1'b1;
				wr_off    = '0;
				pm_d      = 2'd1;
			end else begin
				pm_d = '0;
			end
		end
	end

	assign wr_data = rx_byte;
	assign wr_len  = len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_q  <= '0;
			len_q <= '0;
		end else begin
			pm_q  <= pm_d;
			len_q <= len_d;
		end
	end

endmodule

[rtl/core/plfc_store.sv]
// Line ring memory, slot pointers and pop readout with output register.
module plfc_store #(
	parameter int SLOTS      = 3,
	parameter int LINE_BYTES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  plfc_pkg::cap_ctl_t            ctl,
	input  logic [7:0]                    wr_data,
	input  logic [$clog2(LINE_BYTES)-1:0] wr_off,
	input  logic [$clog2(LINE_BYTES)-1:0] wr_len,
	input  logic                          pop_start,
	input  logic                          out_stall,
	output logic                          out_valid,
	output logic [7:0]                    line_char,
	output logic                          is_last,
	output logic                          queue_empty,
	output plfc_pkg::store_status_t       st
);
	import plfc_pkg::*;

	localparam int LW    = $clog2(LINE_BYTES);
	localparam int SW    = $clog2(SLOTS);
	localparam int DEPTH = SLOTS * LINE_BYTES;
	localparam int AW    = $clog2(DEPTH);

	logic [7:0]    mem [DEPTH];
	logic [LW-1:0] slot_len_q [SLOTS];

	logic [SW-1:0] wr_slot_q, rd_slot_q, pop_slot_q;
	logic [SW-1:0] wr_next, rd_next;
	logic [LW-1:0] pop_len_q, k_q;
	pop_state_t    state_q;

	logic          rd_valid_s1, rd_last_s1;
	logic [7:0]    rd_data_s1;
	logic          out_valid_q, is_last_q, queue_empty_q;
	logic [7:0]    line_char_q;

	logic          ring_empty, issue, issue_last, out_load;
	logic [AW-1:0] wr_addr, rd_addr;

	assign wr_next    = (wr_slot_q == SW'(SLOTS - 1)) ? '0 : wr_slot_q + 1'b1;
	assign rd_next    = (rd_slot_q == SW'(SLOTS - 1)) ? '0 : rd_slot_q + 1'b1;
	assign ring_empty = (wr_slot_q == rd_slot_q);

	assign wr_addr = AW'(wr_slot_q) * AW'(LINE_BYTES) + AW'(wr_off);
	assign rd_addr = AW'(pop_slot_q) * AW'(LINE_BYTES) + AW'(k_q);

	assign out_load   = rd_valid_s1 && (!out_valid_q || !out_stall);
	assign issue      = (state_q == ST_POP) && !(rd_valid_s1 && !out_load);
	assign issue_last = (k_q == pop_len_q - 1'b1);

	// bytes go straight into the open slot; the slot at wr_slot_q is never live
	always_ff @(posedge clk) begin
		if (ctl.wr_en)
			mem[wr_addr] <= wr_data;
		if (issue)
			rd_data_s1 <= mem[rd_addr];
		if (ctl.store)
			slot_len_q[wr_slot_q] <= wr_len;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_slot_q   <= '0;
			rd_slot_q   <= '0;
			pop_slot_q  <= '0;
			pop_len_q   <= '0;
			k_q         <= '0;
			state_q     <= ST_IDLE;
			rd_valid_s1 <= 1'b0;
			rd_last_s1  <= 1'b0;
		end else begin
			if (ctl.store) begin
				wr_slot_q <= wr_next;
				if (wr_next == rd_slot_q)
					rd_slot_q <= rd_next;  // ring full: drop oldest
			end
			if (pop_start && !ring_empty) begin
				pop_slot_q <= rd_slot_q;
				pop_len_q  <= slot_len_q[rd_slot_q];
				k_q        <= '0;
				rd_slot_q  <= rd_next;
				state_q    <= ST_POP;
			end
			if (issue) begin
				rd_valid_s1 <= 1'b1;
				rd_last_s1  <= issue_last;
				k_q         <= k_q + 1'b1;
				if (issue_last)
					state_q <= ST_IDLE;
			end else if (out_load) begin
				rd_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load || (pop_start && ring_empty)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			line_char_q   <= rd_data_s1;
			is_last_q     <= rd_last_s1;
			queue_empty_q <= 1'b0;
		end else if (pop_start && ring_empty) begin
			line_char_q   <= '0;
			is_last_q     <= 1'b1;
			queue_empty_q <= 1'b1;
		end
	end

	assign out_valid     = out_valid_q;
	assign line_char     = line_char_q;
	assign is_last       = is_last_q;
	assign queue_empty   = queue_empty_q;
	assign st.pop_busy   = (state_q == ST_POP);
	assign st.drain_busy = rd_valid_s1 || (out_valid_q && out_stall);

	a_no_write_during_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(ctl.wr_en && (pop_start || state_q == ST_POP)))
		else $error("byte write overlaps a pop");

	a_store_leaves_line: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.store |=> (wr_slot_q != rd_slot_q))
		else $error("ring empty right after storing a line");

	a_pop_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POP) |-> (pop_len_q != '0))
		else $error("reading out a zero-length line");

	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && queue_empty_q) |-> is_last_q)
		else $error("empty result without last mark");

endmodule

[rtl/core/prefix_filtered_line_capture.sv]
// Top level of the prefix-filtered line capture block.
//
// Received bytes (mode 0) are scanned for the prefix "URC:"; a matched line,
// prefix included, of up to LINE_BYTES-1 bytes is written byte by byte
// straight into the free slot of a line ring held in one synchronous memory
// of SLOTS*LINE_BYTES bytes, and committed on CR or LF. The ring keeps at
// most SLOTS-1 lines and drops the oldest when a new one lands on a full
// ring. A pop item (mode 1) reads the oldest line out of the memory, one
// byte per cycle while the output is not stalled, through the single read
// port; each byte comes out as one item with is_last on the final one. A
// pop on an empty ring gives one item with queue_empty and is_last set and
// line_char zero. While a pop runs, the input is stalled; bytes may enter
// again while the last popped bytes are still draining, and a new pop waits
// until the output side is clear. No clearing pass is needed after reset:
// only written memory entries are ever read.
module prefix_filtered_line_capture #(
	parameter int SLOTS      = 3,
	parameter int LINE_BYTES = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       mode,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] line_char,
	output logic       is_last,
	output logic       queue_empty
);
	import plfc_pkg::*;

	localparam int LW = $clog2(LINE_BYTES);

	cap_ctl_t      ctl;
	store_status_t st;
	logic [7:0]    wr_data;
	logic [LW-1:0] wr_off, wr_len;
	logic          in_acc, byte_en, pop_start;

	// bytes are held only by a running pop; a pop also waits for the output path
	assign in_stall  = st.pop_busy || (mode && st.drain_busy);
	assign in_acc    = in_valid && !in_stall;
	assign byte_en   = in_acc && !mode;
	assign pop_start = in_acc && mode;

	plfc_matcher #(
		.LINE_BYTES(LINE_BYTES)
	) u_matcher (
		.clk     (clk),
		.arst_n  (arst_n),
		.byte_en (byte_en),
		.rx_byte (rx_byte),
		.ctl     (ctl),
		.wr_data (wr_data),
		.wr_off  (wr_off),
		.wr_len  (wr_len)
	);

	plfc_store #(
		.SLOTS      (SLOTS),
		.LINE_BYTES (LINE_BYTES)
	) u_store (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.wr_data     (wr_data),
		.wr_off      (wr_off),
		.wr_len      (wr_len),
		.pop_start   (pop_start),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.line_char   (line_char),
		.is_last     (is_last),
		.queue_empty (queue_empty),
		.st          (st)
	);

endmodule

[test/tb_prefix_filtered_line_capture.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the prefix-filtered line capture block.
module tb_prefix_filtered_line_capture;
	import plfc_pkg::*;

	localparam int SLOTS       = 3;
	localparam int LINE_BYTES  = 16;
	localparam int ITEM_TARGET = 330;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 32;
	localparam logic [31:0] URC_TAG = "URC:";

	typedef enum logic {
		OP_RX  = 1'b0,
		OP_POP = 1'b1
	} op_t;

	// One popped byte as it shows on the output
	typedef struct packed {
		logic [7:0] ch;
		logic       last;
		logic       empty;
	} line_out_t;

	// Directed row: when fixed is set, want is the result typed in by hand
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       fixed;
		line_out_t  want;
	} plan_row_t;

	localparam line_out_t EMPTY_POP = {8'h00, 1'b1, 1'b1};
	localparam line_out_t NO_RESULT = {8'h00, 1'b0, 1'b0};

	// Directed part: empty pops, CR/LF with no line open, a repeated 'U' that
	// restarts the match, zero and 0xFF bytes inside a line, and a third line
	// landing on a full ring so the oldest one is dropped.
	plan_row_t directed_plan [25] = '{
		{OP_POP, 8'h00, 1'b1, EMPTY_POP},
		{OP_RX,  8'h0D, 1'b0, NO_RESULT},
		{OP_RX,  8'h0A, 1'b0, NO_RESULT},
		{OP_RX,  8'h55, 1'b0, NO_RESULT},
		{OP_RX,  8'h55, 1'b0, NO_RESULT},
		{OP_RX,  8'h52, 1'b0, NO_RESULT},
		{OP_RX,  8'h43, 1'b0, NO_RESULT},
		{OP_RX,  8'h3A, 1'b0, NO_RESULT},
		{OP_RX,  8'h00, 1'b0, NO_RESULT},
		{OP_RX,  8'hFF, 1'b0, NO_RESULT},
		{OP_RX,  8'h0D, 1'b0, NO_RESULT},
		{OP_RX,  8'h55, 1'b0, NO_RESULT},
		{OP_RX,  8'h52, 1'b0, NO_RESULT},
		{OP_RX,  8'h43, 1'b0, NO_RESULT},
		{OP_RX,  8'h3A, 1'b0, NO_RESULT},
		{OP_RX,  8'h0A, 1'b0, NO_RESULT},
		{OP_RX,  8'h55, 1'b0, NO_RESULT},
		{OP_RX,  8'h52, 1'b0, NO_RESULT},
		{OP_RX,  8'h43, 1'b0, NO_RESULT},
		{OP_RX,  8'h3A, 1'b0, NO_RESULT},
		{OP_RX,  8'h7F, 1'b0, NO_RESULT},
		{OP_RX,  8'h0D, 1'b0, NO_RESULT},
		{OP_POP, 8'h00, 1'b0, NO_RESULT},
		{OP_POP, 8'hAA, 1'b0, NO_RESULT},
		{OP_POP, 8'hFF, 1'b1, EMPTY_POP}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic       mode = 1'b0;
	logic [7:0] rx_byte = 8'h00;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] line_char;
	logic       is_last;
	logic       queue_empty;

	// Line capture model state
	int unsigned urc_count = 0;    // prefix characters matched so far
	int unsigned line_len = 0;     // bytes in the open line, 0 = none open
	int unsigned wr_slot = 0;
	int unsigned rd_slot = 0;
	logic [7:0]  line_buf [LINE_BYTES];
	logic [7:0]  ring_buf [SLOTS][LINE_BYTES];
	int unsigned ring_len [SLOTS];

	// Bytes a pop produces, filled by predict_item
	line_out_t pop_out [LINE_BYTES];
	int        pop_count = 0;

	line_out_t expected_chars [$];

	int errors = 0;
	int items_sent = 0;
	int burst_left = 0;
	int cycle_count = 0;
	int stall_level = 0;
	int stall_phase_left = 0;

	prefix_filtered_line_capture #(
		.SLOTS(SLOTS),
		.LINE_BYTES(LINE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.line_char(line_char),
		.is_last(is_last),
		.queue_empty(queue_empty)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [7:0] tag_char(input int unsigned idx);
		return URC_TAG[31 - 8 * idx -: 8];
	endfunction

	// One received byte through the prefix matcher and line collector
	task automatic take_rx(input logic [7:0] b);
		int unsigned nxt;
		if (b == CH_CR || b == CH_LF) begin
			if (line_len > 0) begin
				// full ring: oldest line goes first
				nxt = (wr_slot + 1) % SLOTS;
				if (nxt == rd_slot)
					rd_slot = (rd_slot + 1) % SLOTS;
				for (int k = 0; k < LINE_BYTES; k++)
					ring_buf[wr_slot][k] = line_buf[k];
				ring_len[wr_slot] = line_len;
				wr_slot = nxt;
			end
			line_len = 0;
			urc_count = 0;
		end else if (line_len > 0) begin
			if (line_len < LINE_BYTES - 1) begin
				line_buf[line_len] = b;
				line_len++;
			end else begin
				// overlong line dropped; this byte is not a prefix candidate
				line_len = 0;
				urc_count = 0;
			end
		end else if (b == tag_char(urc_count)) begin
			line_buf[urc_count] = b;
			urc_count++;
			if (urc_count == TAG_CHARS) begin
				line_len = TAG_CHARS;
				urc_count = 0;
			end
		end else if (b == CH_U) begin
			// broken match, but 'U' opens a fresh one
			line_buf[0] = b;
			urc_count = 1;
		end else begin
			urc_count = 0;
		end
	endtask

	// Advance the model by one item; results land in pop_out[0 .. pop_count-1]
	task automatic predict_item(input op_t op, input logic [7:0] b);
		int unsigned n;
		pop_count = 0;
		if (op == OP_RX) begin
			take_rx(b);
		end else if (wr_slot == rd_slot) begin
			pop_out[0] = EMPTY_POP;
			pop_count = 1;
		end else begin
			n = ring_len[rd_slot];
			for (int k = 0; k < n; k++)
				pop_out[k] = {ring_buf[rd_slot][k], k == n - 1, 1'b0};
			pop_count = n;
			rd_slot = (rd_slot + 1) % SLOTS;
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
			input logic [7:0] want);
		if (errors < 40)
			$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	// Present one item, idling first when a burst has run out. The model is
	// advanced on presentation: valid holds until acceptance, so the item is
	// committed, and a pop may start emitting before its own handshake.
	task automatic send_item(input op_t op, input logic [7:0] b,
			input logic fixed = 1'b0, input line_out_t want = NO_RESULT);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? 40 : $urandom_range(1, 12);
		end
		predict_item(op, b);
		if (fixed)
			expected_chars.push_back(want);
		else
			for (int k = 0; k < pop_count; k++)
				expected_chars.push_back(pop_out[k]);
		in_valid <= 1'b1;
		mode <= op;
		rx_byte <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
		burst_left--;
	endtask

	// Hold off the sender until every predicted byte has come out
	task automatic wait_for_results();
		in_valid <= 1'b0;
		burst_left = 0;
		do
			@(posedge clk);
		while (expected_chars.size() != 0);
	endtask

	initial begin : stimulus
		int pick;
		int len;
		int r;
		logic [7:0] b;

		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_plan[i])
			send_item(directed_plan[i].op, directed_plan[i].data,
				directed_plan[i].fixed, directed_plan[i].want);
		wait_for_results();

		// Random part: well-formed lines with random content, some of them too long
		// to keep, plus broken prefixes, raw noise and pops.
		while (items_sent < ITEM_TARGET) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				repeat ($urandom_range(0, 2))
					send_item(OP_RX, 8'($urandom_range(0, 255)));
				for (int k = 0; k < TAG_CHARS; k++)
					send_item(OP_RX, tag_char(k));
				r = $urandom_range(0, 9);
				if (r < 6)
					len = $urandom_range(0, 6);
				else if (r < 9)
					len = $urandom_range(7, LINE_BYTES - 1 - TAG_CHARS);
				else
					len = $urandom_range(LINE_BYTES - TAG_CHARS, LINE_BYTES - 2);
				for (int k = 0; k < len; k++) begin
					b = 8'($urandom_range(0, 255));
					if (b == CH_CR || b == CH_LF)
						b = 8'h00;
					send_item(OP_RX, b);
				end
				send_item(OP_RX, $urandom_range(0, 1) ? CH_CR : CH_LF);
			end else if (pick < 60) begin
				len = $urandom_range(1, TAG_CHARS - 1);
				for (int k = 0; k < len; k++)
					send_item(OP_RX, tag_char(k));
				send_item(OP_RX, 8'($urandom_range(0, 255)));
			end else if (pick < 75) begin
				repeat ($urandom_range(1, 4))
					send_item(OP_RX, 8'($urandom_range(0, 255)));
			end else begin
				repeat ($urandom_range(1, 2))
					send_item(OP_POP, 8'($urandom_range(0, 255)));
				if ($urandom_range(0, 9) == 0)
					wait_for_results();
			end
		end

		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Output checker: each accepted byte against the oldest prediction
	always @(posedge clk) begin : check_output
		line_out_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_chars.size() == 0) begin
				report_mismatch("unexpected output byte", line_char, 8'h00);
			end else begin
				want = expected_chars.pop_front();
				if (line_char !== want.ch)
					report_mismatch("line_char", line_char, want.ch);
				if (is_last !== want.last)
					report_mismatch("is_last", 8'(is_last), 8'(want.last));
				if (queue_empty !== want.empty)
					report_mismatch("queue_empty", 8'(queue_empty), 8'(want.empty));
			end
		end
	end

	// Receiver stall: phases of no stall, light stall and heavy stall
	always @(posedge clk) begin
		if (stall_phase_left == 0) begin
			stall_level = $urandom_range(0, 3);
			stall_phase_left = $urandom_range(8, 60);
		end
		stall_phase_left--;
		case (stall_level)
			1: begin
				out_stall <= ($urandom_range(0, 3) == 0);
			end
			2: begin
				out_stall <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				out_stall <= 1'b0;
			end
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
